FILE: rtl/mpp_pkg.sv
// Shared types and constants for the minimum palindrome partition block.
package mpp_pkg;

   localparam int MAX_LEN_DEFAULT = 256;
   localparam int CHAR_W          = 8;
   localparam int PIECES_W        = 9;
   localparam int PIECES_MAX      = 511;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } mpp_req_type;

   typedef struct packed {
      logic [PIECES_W-1:0] min_pieces;
      logic                too_long;
   } mpp_rsp_type;

   typedef struct packed {
      logic              start;
      logic [CHAR_W-1:0] char_code;
   } mpp_walk_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mpp_walk_status_type;

endpackage

FILE: rtl/mpp_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
module mpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = mpp_pkg::MAX_LEN_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mpp_walk.sv
// Walk engine: rebuilds the palindrome row and the best piece count for one new byte.
module mpp_walk #(
   parameter int MAX_LEN = mpp_pkg::MAX_LEN_DEFAULT,
   localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
   localparam int CW     = $clog2(MAX_LEN + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mpp_pkg::mpp_walk_cmd_type    cmd,
   input  logic [AW-1:0]                start_pos,
   output mpp_pkg::mpp_walk_status_type status,
   output logic [CW-1:0]                best
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [AW-1:0]               j_ff, j_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic [mpp_pkg::CHAR_W-1:0]  char_ff, char_in;
   logic [CW-1:0]               best_ff, best_in;
   logic                        s2_valid_ff, s2_valid_in;
   logic [AW-1:0]               s2_j_ff, s2_j_in;

   logic                        issue;
   logic [mpp_pkg::CHAR_W-1:0]  cs_rd;
   logic                        pal_rd;
   logic [CW-1:0]               bc_rd;
   logic                        s2_end;
   logic                        inner;
   logic                        mark;
   logic [CW-1:0]               cand;

   assign issue = (state_ff == ST_WALK);

   mpp_ram #(.WIDTH(mpp_pkg::CHAR_W), .DEPTH(MAX_LEN)) u_char_ram (
      .clock   (clock),
      .wr_en   (cmd.start && state_ff == ST_IDLE),
      .wr_addr (start_pos),
      .wr_data (cmd.char_code),
      .rd_en   (issue),
      .rd_addr (j_ff),
      .rd_data (cs_rd)
   );

   // Old mark j+1 is read before mark j+1 is rewritten.
   mpp_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_pal_ram (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_j_ff),
      .wr_data (mark),
      .rd_en   (issue),
      .rd_addr (AW'({1'b0, j_ff} + (AW+1)'(1))),
      .rd_data (pal_rd)
   );

   mpp_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_best_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_FIN),
      .wr_addr (pos_ff),
      .wr_data (best_ff),
      .rd_en   (issue),
      .rd_addr (j_ff - AW'(1)),
      .rd_data (bc_rd)
   );

   always_comb begin
      s2_end = (s2_j_ff == pos_ff);
      inner  = (({1'b0, s2_j_ff} + (AW+1)'(2)) >= {1'b0, pos_ff}) || pal_rd;
      mark   = s2_end || ((cs_rd == char_ff) && inner);
      cand   = (s2_j_ff == '0) ? CW'(1) : (bc_rd + CW'(1));
   end

   always_comb begin
      state_in    = state_ff;
      j_in        = j_ff;
      pos_in      = pos_ff;
      char_in     = char_ff;
      best_in     = best_ff;
      s2_valid_in = issue;
      s2_j_in     = j_ff;
      if (s2_valid_ff && mark && (cand < best_ff)) begin
         best_in = cand;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_WALK;
               j_in     = '0;
               pos_in   = start_pos;
               char_in  = cmd.char_code;
               best_in  = CW'({1'b0, start_pos}) + CW'(1);
            end
         end
         ST_WALK: begin
            if (j_ff == pos_ff) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + AW'(1);
            end
         end
         ST_DRAIN: state_in = ST_FIN;
         ST_FIN:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      pos_ff  <= pos_in;
      char_ff <= char_in;
      best_ff <= best_in;
      s2_j_ff <= s2_j_in;
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_FIN);
   assign best        = best_ff;

endmodule

FILE: rtl/min_palindrome_partition_top.sv
// Top level of the minimum palindrome partition block: handshakes, length tracking, result word.
//
//   channel  ports                        direction  word
//   request  req_valid req_stall req_data in         mpp_req_type (char_code, last_char)
//   response rsp_valid rsp_stall rsp_data out        mpp_rsp_type (min_pieces, too_long)
//
// A byte at position p (0-based) is not accepted until the walk for it has finished; the walk
// visits one entry of the char, mark and count memories per cycle.
// A final byte passes through the emit state, which loads the response word; a dropped byte
// starts no walk, and a dropped final byte also passes through the emit state.
// Reset clears control state only; memory entries are written before their data is used.
// The response register holds while rsp_stall is high; a final byte waits for it to drain.
module min_palindrome_partition_top #(
   parameter int MAX_LEN = mpp_pkg::MAX_LEN_DEFAULT,
   localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
   localparam int CW     = $clog2(MAX_LEN + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mpp_pkg::mpp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mpp_pkg::mpp_rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam int XW = (CW > mpp_pkg::PIECES_W) ? CW : mpp_pkg::PIECES_W;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        len_ff, len_in;
   logic                 ovf_ff, ovf_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mpp_pkg::mpp_rsp_type rsp_data_ff, rsp_data_in;

   logic                         accept;
   logic                         take;
   mpp_pkg::mpp_walk_cmd_type    cmd;
   mpp_pkg::mpp_walk_status_type walk_status;
   logic [CW-1:0]                best;
   logic [XW-1:0]                best_wide;
   logic [mpp_pkg::PIECES_W-1:0] pieces;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign take      = (len_ff < CW'(MAX_LEN));

   assign cmd.start     = accept && take;
   assign cmd.char_code = req_data.char_code;

   mpp_walk #(.MAX_LEN(MAX_LEN)) u_walk (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .start_pos (AW'(len_ff)),
      .status    (walk_status),
      .best      (best)
   );

   // Saturate the count to the response field.
   always_comb begin
      best_wide = XW'(best);
      if (best_wide > XW'(mpp_pkg::PIECES_MAX)) begin
         pieces = mpp_pkg::PIECES_W'(mpp_pkg::PIECES_MAX);
      end else begin
         pieces = best_wide[mpp_pkg::PIECES_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_data.last_char;
               if (take) begin
                  state_in = ST_RUN;
               end else begin
                  // Drop the byte and flag the string.
                  ovf_in = 1'b1;
                  if (req_data.last_char) begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_RUN: begin
            if (walk_status.done) begin
               len_in   = len_ff + CW'(1);
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.too_long   = ovf_ff;
               rsp_data_in.min_pieces = ovf_ff ? '0 : pieces;
               len_in                 = '0;
               ovf_in                 = 1'b0;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: dv/tb_min_palindrome_partition_top.sv
// Testbench for min_palindrome_partition_top: directed and random strings against an in-bench partition model.
module tb_min_palindrome_partition_top;
   import mpp_pkg::*;

   localparam int STR_MAX     = MAX_LEN_DEFAULT;
   localparam int QUIET_LIMIT = 5000;
   localparam int TAIL_CYCLES = STR_MAX + 16;
   localparam int REPORT_MAX  = 10;
   localparam int RANDOM_WORDS = 900;

   typedef enum int {STR_NOISE, STR_PAIR, STR_MIRROR, STR_CHAIN} str_style_type;

   typedef struct {
      mpp_req_type word;
      bit          drain_first;
   } send_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   mpp_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   mpp_rsp_type rsp_data;

   send_entry_type send_queue[$];
   mpp_rsp_type    pending_results[$];
   int             fail_count = 0;

   // partition model state
   logic [7:0]  seen_chars [STR_MAX];
   bit          pal_marks  [STR_MAX];
   int unsigned prefix_best[STR_MAX];
   int unsigned held_len = 0;
   bit          dropped  = 1'b0;

   min_palindrome_partition_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advance the model by one byte; return 1 when the byte closes a string.
   function automatic bit predict_partition(input mpp_req_type w, output mpp_rsp_type r);
      int unsigned pos;
      int unsigned best;
      int unsigned cand;
      bit          inner;
      r = '0;
      if (held_len < STR_MAX) begin
         pos = held_len;
         seen_chars[pos] = w.char_code;
         // ascending: mark j reads the not yet rebuilt mark j+1
         for (int j = 0; j < pos; j++) begin
            inner = (j + 2 >= pos) ? 1'b1 : pal_marks[j + 1];
            pal_marks[j] = (seen_chars[j] == w.char_code) && inner;
         end
         pal_marks[pos] = 1'b1;
         best = pos + 1;
         for (int j = 0; j <= pos; j++) begin
            if (pal_marks[j]) begin
               cand = 1 + ((j == 0) ? 0 : prefix_best[j - 1]);
               if (cand < best) best = cand;
            end
         end
         prefix_best[pos] = best;
         held_len = pos + 1;
      end else begin
         dropped = 1'b1;
      end
      if (!w.last_char) return 1'b0;
      r.too_long = dropped;
      if (!dropped && held_len > 0) begin
         best = prefix_best[held_len - 1];
         if (best > PIECES_MAX) best = PIECES_MAX;
         r.min_pieces = best[PIECES_W-1:0];
      end
      pal_marks = '{default: 1'b0};
      held_len = 0;
      dropped = 1'b0;
      return 1'b1;
   endfunction

   function automatic int draw_wait(input bit active);
      return active ? int'($urandom_range(0, 11)) : 0;
   endfunction

   function automatic void build_string(input int len, output logic [7:0] str[$]);
      str_style_type style;
      logic [7:0] base;
      logic [7:0] half[$];
      int         piece;
      str = {};
      style = str_style_type'($urandom_range(0, 3));
      base = 8'($urandom());
      case (style)
         STR_NOISE: repeat (len) str = {str, 8'($urandom())};
         STR_PAIR: repeat (len) str = {str, base ^ 8'($urandom_range(0, 1))};
         STR_MIRROR: begin
            repeat ((len + 1) / 2) half = {half, 8'(base + 8'($urandom_range(0, 2)))};
            str = half;
            for (int i = len / 2 - 1; i >= 0; i--) str = {str, half[i]};
         end
         default: begin
            // chain short palindromes
            while (str.size() < len) begin
               piece = $urandom_range(1, 5);
               if (piece > len - str.size()) piece = len - str.size();
               half = {};
               repeat ((piece + 1) / 2) half = {half, 8'(base + 8'($urandom_range(0, 2)))};
               for (int i = 0; i < half.size(); i++) str = {str, half[i]};
               for (int i = piece / 2 - 1; i >= 0; i--) str = {str, half[i]};
            end
         end
      endcase
   endfunction

   task automatic queue_string(input logic [7:0] str[$], input bit drain);
      send_entry_type item;
      for (int i = 0; i < str.size(); i++) begin
         item.word.char_code = str[i];
         item.word.last_char = (i == str.size() - 1);
         item.drain_first    = drain && (i == 0);
         send_queue = {send_queue, item};
      end
   endtask

   // driver
   logic           next_valid;
   mpp_req_type    next_data;
   mpp_rsp_type    predicted;
   send_entry_type head;
   bit             req_fire;
   int             send_wait = 0;
   bit             send_idle = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         req_fire = req_valid && !req_stall;
         next_valid = 1'b0;
         next_data = req_data;
         if (req_fire) begin
            if (predict_partition(req_data, predicted))
               pending_results = {pending_results, predicted};
            send_wait = draw_wait(send_idle);
            if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
         end
         if (req_valid && !req_fire) begin
            // hold the stalled word
            next_valid = 1'b1;
         end else if (send_wait != 0) begin
            send_wait--;
         end else if (send_queue.size() != 0 &&
                      (!send_queue[0].drain_first || pending_results.size() == 0)) begin
            head = send_queue.pop_front();
            next_valid = 1'b1;
            next_data = head.word;
         end
         req_valid <= next_valid;
         req_data  <= next_data;
      end
   end

   // monitor
   mpp_rsp_type want;
   int          recv_wait = 0;
   bit          recv_idle = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected result word: min_pieces=%0d too_long=%0b",
                           rsp_data.min_pieces, rsp_data.too_long);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.min_pieces !== want.min_pieces ||
                   rsp_data.too_long !== want.too_long) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display({"result mismatch: min_pieces exp %0d got %0d, ",
                               "too_long exp %0b got %0b"},
                              want.min_pieces, rsp_data.min_pieces,
                              want.too_long, rsp_data.too_long);
               end
            end
            recv_wait = draw_wait(recv_idle);
            if ($urandom_range(0, 7) == 0) recv_idle = !recv_idle;
         end else if (rsp_valid && recv_wait != 0) begin
            recv_wait--;
         end
         rsp_stall <= (recv_wait != 0);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] str[$];
      int         random_words;
      int         long_done;
      int         len;
      random_words = 0;
      long_done = 0;

      // directed: single bytes at the extremes, short palindromes and near misses
      str = {8'h00};                      queue_string(str, 1'b1);
      str = {8'hFF};                      queue_string(str, 1'b0);
      str = {8'h00, 8'h00};               queue_string(str, 1'b0);
      str = {8'h00, 8'hFF};               queue_string(str, 1'b1);
      str = {8'hFF, 8'h00, 8'hFF};        queue_string(str, 1'b0);
      str = {8'h01, 8'h02, 8'h02, 8'h01}; queue_string(str, 1'b0);
      str = {8'h55, 8'h55, 8'h55};        queue_string(str, 1'b0);
      str = {8'hAA, 8'h55, 8'hAA, 8'h7E}; queue_string(str, 1'b1);

      // random: mostly short strings, one of exactly full length, one that overflows
      while (random_words < RANDOM_WORDS) begin
         if ((random_words >= 250 && long_done == 0) ||
             (random_words >= 550 && long_done == 1)) begin
            len = (long_done == 0) ? STR_MAX : STR_MAX + $urandom_range(1, 4);
            long_done++;
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         end
         build_string(len, str);
         queue_string(str, $urandom_range(0, 7) == 0);
         random_words += len;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (send_queue.size() != 0 || req_valid || pending_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/mpp_pkg.sv
rtl/mpp_ram.sv
rtl/mpp_walk.sv
rtl/min_palindrome_partition_top.sv
dv/tb_min_palindrome_partition_top.sv
